FILE: hdl/gae_pkg.sv
// shared types and constants of the grain envelope core
package gae_pkg;

  localparam int unsigned GainW    = 16;
  localparam int unsigned DivSteps = GainW;
  localparam logic [GainW-1:0] Unity = 16'h8000;

  localparam int unsigned CfgIdxW = 3;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegGrainLength    = 3'd0;
  localparam cfg_idx_t RegAttackSamples  = 3'd1;
  localparam cfg_idx_t RegDecaySamples   = 3'd2;
  localparam cfg_idx_t RegReleaseSamples = 3'd3;
  localparam cfg_idx_t RegSustainLevel   = 3'd4;

  localparam int unsigned GrainLengthRst = 4800;
  localparam int unsigned SegmentRst     = 480;
  localparam logic [GainW-1:0] SustainRst = 16'd26214;

  typedef struct packed {
    logic load;
    logic seg;
    logic mul;
    logic num;
    logic div_step;
    logic out_load;
  } gae_cmd_t;

  typedef struct packed {
    logic div_last;
  } gae_status_t;

endpackage

FILE: hdl/gae_if.sv
// request, result and configuration channel interfaces
interface gae_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface gae_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           grain_end;

  modport source (output valid, output sample_out, output grain_end, input ready);
  modport sink (input valid, input sample_out, input grain_end, output ready);
endinterface

interface gae_cfg_if import gae_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              reg_index;
  logic [DATA_WIDTH-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

FILE: hdl/gae_datapath.sv
// envelope datapath: registers, segment select, multiplier, serial divider, scaling
module gae_datapath import gae_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16,
  parameter int unsigned CFG_WIDTH    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gae_cmd_t                       cmd_i,
  output gae_status_t                    status_o,
  input  logic                           cfg_we_i,
  input  cfg_idx_t                       cfg_index_i,
  input  logic [CFG_WIDTH-1:0]           cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic                           grain_end_o
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned NumW = COUNT_WIDTH + GainW;
  localparam int unsigned PosW = COUNT_WIDTH + 2;
  localparam int unsigned CntW = $clog2(DivSteps);
  localparam int unsigned ProdW = SAMPLE_WIDTH + GainW + 1;
  localparam logic signed [PosW-1:0] OneS = PosW'(1);

  logic [CW-1:0]    len_q, att_q, dec_q, rel_q;
  logic [GainW-1:0] sus_q;
  logic [CW-1:0]    idx_q, idx_d;

  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic                           last_q, last_d;
  logic [CW-1:0]    op_a_q, op_a_d;
  logic [GainW-1:0] op_b_q, op_b_d;
  logic [CW-1:0]    den_q, den_d;
  logic             decay_q, decay_d;
  logic [NumW-1:0]  prod_q, num_c;
  logic [CW-1:0]    rem_q;
  logic [GainW-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic                           end_q;

  logic [CW-1:0]    len1, a1, d1, r1;
  logic [GainW-1:0] sus_sat;
  logic signed [PosW-1:0] idx_s, a_s, de_s, se_raw, se_s, lm1_s, left_s, rel_den_s;
  logic [CW:0]      trial;
  logic             fits;
  logic signed [ProdW-1:0] scaled;

  // zero lengths act as one, sustain saturates at unity
  assign len1    = (len_q == '0) ? CW'(1) : len_q;
  assign a1      = (att_q == '0) ? CW'(1) : att_q;
  assign d1      = (dec_q == '0) ? CW'(1) : dec_q;
  assign r1      = (rel_q == '0) ? CW'(1) : rel_q;
  assign sus_sat = (sus_q > Unity) ? Unity : sus_q;

  assign idx_s     = signed'({2'b00, idx_q});
  assign a_s       = signed'({2'b00, a1});
  assign de_s      = a_s + signed'({2'b00, d1});
  assign se_raw    = signed'({2'b00, len1}) - signed'({2'b00, r1});
  assign se_s      = (se_raw < de_s) ? de_s : se_raw;
  assign lm1_s     = signed'({2'b00, len1}) - OneS;
  assign left_s    = lm1_s - idx_s;
  assign rel_den_s = lm1_s - se_s;

  always_comb begin
    op_a_d  = '0;
    op_b_d  = sus_sat;
    den_d   = CW'(1);
    decay_d = 1'b0;
    if (idx_s < a_s) begin
      op_a_d = idx_q;
      op_b_d = Unity;
      den_d  = a1;
    end else if (idx_s < de_s) begin
      op_a_d  = CW'(idx_s - a_s);
      op_b_d  = Unity - sus_sat;
      den_d   = d1;
      decay_d = 1'b1;
    end else if (idx_s < se_s) begin
      op_a_d = CW'(1);
    end else if (lm1_s > se_s) begin
      op_a_d = left_s[PosW-1] ? '0 : CW'(left_s);
      den_d  = CW'(rel_den_s);
    end
  end

  assign last_d = (idx_q >= (len1 - CW'(1)));
  assign idx_d  = last_d ? '0 : idx_q + CW'(1);

  assign num_c = decay_q ? ((NumW'(den_q) << (GainW - 1)) - prod_q) : prod_q;

  assign trial = {rem_q, quo_q[GainW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign scaled = smp_q * signed'({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CW'(GrainLengthRst);
      att_q <= CW'(SegmentRst);
      dec_q <= CW'(SegmentRst);
      rel_q <= CW'(SegmentRst);
      sus_q <= SustainRst;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegGrainLength:    len_q <= cfg_data_i[CW-1:0];
          RegAttackSamples:  att_q <= cfg_data_i[CW-1:0];
          RegDecaySamples:   dec_q <= cfg_data_i[CW-1:0];
          RegReleaseSamples: rel_q <= cfg_data_i[CW-1:0];
          RegSustainLevel:   sus_q <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.seg) begin
        idx_q <= idx_d;
      end
      if (cmd_i.num) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q  <= sample_i;
      last_q <= last_d;
    end
    if (cmd_i.seg) begin
      op_a_q  <= op_a_d;
      op_b_q  <= op_b_d;
      den_q   <= den_d;
      decay_q <= decay_d;
    end
    if (cmd_i.mul) begin
      prod_q <= NumW'(op_a_q) * NumW'(op_b_q);
    end
    if (cmd_i.num) begin
      rem_q <= num_c[NumW-1:GainW];
      quo_q <= num_c[GainW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? CW'(trial - {1'b0, den_q}) : trial[CW-1:0];
      quo_q <= {quo_q[GainW-2:0], fits};
    end
    if (cmd_i.out_load) begin
      out_q <= scaled[SAMPLE_WIDTH+GainW-2:GainW-1];
      end_q <= last_q;
    end
  end

  assign status_o.div_last = (cnt_q == CntW'(DivSteps - 1));
  assign sample_o          = out_q;
  assign grain_end_o       = end_q;

endmodule

FILE: hdl/gae_ctrl.sv
// sequencing state machine and result valid flag
module gae_ctrl import gae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  gae_status_t status_i,
  output gae_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSeg  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StNum  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSeg;
        end
      end
      StSeg: begin
        cmd_o.seg = 1'b1;
        state_d   = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StNum;
      end
      StNum: begin
        cmd_o.num = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/grain_adsr_envelope_core.sv
// top level of the grain envelope core
//
//  port   | dir  | contents
//  cfg_i  | in   | reg_index, reg_data (register writes)
//  req_i  | in   | sample_in
//  rsp_o  | out  | sample_out, grain_end
//
// one request passes through segment select, multiply, numerator, the 16
// one-bit steps of the serial gain divider and scaling before its result
// is ready. the next request is accepted the cycle after the result is
// loaded, even while it waits to be taken.
// reset restores the register defaults and returns the grain index to zero.
// a stalled result holds the output register and the final scaling step.
module grain_adsr_envelope_core import gae_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gae_cfg_if.sink   cfg_i,
  gae_in_if.sink    req_i,
  gae_out_if.source rsp_o
);

  localparam int unsigned CfgW = (COUNT_WIDTH > GainW) ? COUNT_WIDTH : GainW;

  gae_cmd_t    cmd;
  gae_status_t status;

  assign cfg_i.ready = 1'b1;

  gae_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CFG_WIDTH    (CfgW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_i.valid && cfg_i.ready),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.reg_data),
    .sample_i    (req_i.sample_in),
    .sample_o    (rsp_o.sample_out),
    .grain_end_o (rsp_o.grain_end)
  );

  gae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one in flight");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result overwritten before it was taken");

  a_valid_rises_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result appeared without a request in flight");
`endif

endmodule
